// ===== design/rlbq_pkg.sv =====
// Shared types, codes and constants for the resistor ladder button qualifier.
`default_nettype none

package rlbq_pkg;

	localparam int SER_W     = 16;
	localparam int TOL_W     = 7;
	localparam int HOLD_W    = 16;
	localparam int RAW_W     = 10;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int BND_W     = 13;
	localparam int OPA_W     = SER_W + 1;
	localparam int REQ_W     = 3;
	localparam int ACT_W     = 2;
	localparam int CODE_W    = 2;
	localparam int WIN_W     = 2;
	localparam int STEP_W    = 3;

	localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

	localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CMD    = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

	localparam logic [REQ_W-1:0] REQ_UP     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DOWN   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ONOFF  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_NONE   = 3'd4;

	localparam logic [WIN_W-1:0] WIN_UP     = 2'd0;
	localparam logic [WIN_W-1:0] WIN_DOWN   = 2'd1;
	localparam logic [WIN_W-1:0] WIN_CANCEL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SERIES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAW = 2'd3;

	localparam logic [HOLD_W-1:0] HOLDOFF_RST = 16'd200;
	localparam logic [TOL_W-1:0]  TOL_RST     = 7'd10;
	localparam logic [SER_W-1:0]  SERIES_RST  = 16'd2000;
	localparam logic [RAW_W-1:0]  MIN_RAW_RST = 10'd100;

	localparam int NOM_UP     = 515;
	localparam int NOM_DOWN   = 142;
	localparam int NOM_CANCEL = 1379;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NUM,
		ST_BND,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic             load;
		logic             mul_num;
		logic             mul_bnd;
		logic [WIN_W-1:0] win;
		logic             bnd_hi;
		logic             cmp_en;
		logic [WIN_W-1:0] cmp_win;
		logic             cmp_hi;
		logic             finish;
	} dp_cmd_t;

	typedef struct packed {
		logic in_is_sample;
	} dp_status_t;

	// Window end: nominal +/- (nominal/100)*tolerance, signed.
	function automatic logic signed [BND_W-1:0] win_bound(
		input logic [WIN_W-1:0] win,
		input logic             hi,
		input logic [TOL_W-1:0] tol
	);
		logic signed [BND_W-1:0] nom;
		logic signed [BND_W-1:0] step;
		logic signed [BND_W-1:0] half;
		unique case (win)
			WIN_UP: begin
				nom  = BND_W'(NOM_UP);
				step = BND_W'(NOM_UP / 100);
			end
			WIN_DOWN: begin
				nom  = BND_W'(NOM_DOWN);
				step = BND_W'(NOM_DOWN / 100);
			end
			WIN_CANCEL: begin
				nom  = BND_W'(NOM_CANCEL);
				step = BND_W'(NOM_CANCEL / 100);
			end
			default: begin
				nom  = '0;
				step = '0;
			end
		endcase
		half = $signed(BND_W'(tol)) * step;
		return hi ? (nom + half) : (nom - half);
	endfunction

endpackage

`default_nettype wire

// ===== design/rlbq_ctrl.sv =====
// Sequencing controller: handshakes, multiply/compare schedule and output beat.
`default_nettype none

module rlbq_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire rlbq_pkg::dp_status_t  status,
	output rlbq_pkg::dp_cmd_t          cmd
);

	rlbq_pkg::ctrl_state_t state_q, state_d;
	logic [rlbq_pkg::STEP_W-1:0] cnt_q;
	logic [rlbq_pkg::STEP_W-1:0] prev_cnt;
	logic out_valid_q;
	logic commit;

	assign prev_cnt  = cnt_q - 1'b1;
	assign commit    = (state_q == rlbq_pkg::ST_FINISH) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == rlbq_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rlbq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = status.in_is_sample ? rlbq_pkg::ST_NUM : rlbq_pkg::ST_FINISH;
				end
			end
			rlbq_pkg::ST_NUM: begin
				state_d = rlbq_pkg::ST_BND;
			end
			rlbq_pkg::ST_BND: begin
				if (cnt_q == rlbq_pkg::LAST_STEP) begin
					state_d = rlbq_pkg::ST_FINISH;
				end
			end
			rlbq_pkg::ST_FINISH: begin
				if (commit) begin
					state_d = rlbq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rlbq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			rlbq_pkg::ST_IDLE: begin
				cmd.load = in_valid;
			end
			rlbq_pkg::ST_NUM: begin
				cmd.mul_num = 1'b1;
			end
			rlbq_pkg::ST_BND: begin
				cmd.mul_bnd = 1'b1;
				cmd.win     = cnt_q[2:1];
				cmd.bnd_hi  = ~cnt_q[0];
				cmd.cmp_en  = (cnt_q != '0);
				cmd.cmp_win = prev_cnt[2:1];
				cmd.cmp_hi  = ~prev_cnt[0];
			end
			rlbq_pkg::ST_FINISH: begin
				cmd.finish = commit;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlbq_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rlbq_pkg::ST_NUM) begin
				cnt_q <= '0;
			end else if (state_q == rlbq_pkg::ST_BND) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/rlbq_dp.sv =====
// Datapath: settings, shared multiplier, window compares, holdoff state, result beat.
`default_nettype none

module rlbq_dp #(
	parameter int ADC_FULL_SCALE = 1024,
	parameter int TICK_BITS      = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rlbq_pkg::dp_cmd_t               cmd,
	output rlbq_pkg::dp_status_t                 status,
	input  wire logic [rlbq_pkg::ACT_W-1:0]      action,
	input  wire logic [rlbq_pkg::RAW_W-1:0]      adc_sample,
	input  wire logic [rlbq_pkg::CODE_W-1:0]     command_code,
	input  wire logic                            cfg_we,
	input  wire logic [rlbq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rlbq_pkg::CFG_W-1:0]      cfg_wdata,
	output logic [rlbq_pkg::REQ_W-1:0]           held_state,
	output logic                                 state_changed,
	output logic [rlbq_pkg::REQ_W-1:0]           requested_state
);

	localparam int DIFF_W = $clog2(ADC_FULL_SCALE + 1) + 1;
	localparam int MB_W   = (DIFF_W > rlbq_pkg::RAW_W + 1) ? DIFF_W : rlbq_pkg::RAW_W + 1;
	localparam int PROD_W = rlbq_pkg::OPA_W + MB_W;
	localparam int EL_W   = (TICK_BITS > rlbq_pkg::HOLD_W) ? TICK_BITS : rlbq_pkg::HOLD_W;

	logic [rlbq_pkg::HOLD_W-1:0] holdoff_q;
	logic [rlbq_pkg::TOL_W-1:0]  tol_q;
	logic [rlbq_pkg::SER_W-1:0]  series_q;
	logic [rlbq_pkg::RAW_W-1:0]  min_raw_q;

	logic [rlbq_pkg::ACT_W-1:0]  action_q;
	logic [rlbq_pkg::RAW_W-1:0]  raw_q;
	logic [rlbq_pkg::CODE_W-1:0] code_q;

	logic signed [PROD_W-1:0] num_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     hi_ok_q;
	logic [rlbq_pkg::REQ_W-1:0] class_q;

	logic [rlbq_pkg::REQ_W-1:0] cur_q;
	logic [TICK_BITS-1:0]       elapsed_q;

	logic [rlbq_pkg::REQ_W-1:0] held_q;
	logic                       changed_q;
	logic [rlbq_pkg::REQ_W-1:0] req_q;

	logic signed [rlbq_pkg::BND_W-1:0] bound;
	logic signed [rlbq_pkg::OPA_W-1:0] opa;
	logic signed [MB_W-1:0]            opb;
	logic signed [PROD_W-1:0]          mul_res;

	logic                       win2_hit;
	logic                       onoff_hit;
	logic [rlbq_pkg::REQ_W-1:0] sample_req;
	logic [rlbq_pkg::REQ_W-1:0] req;
	logic                       offers;
	logic                       differ;
	logic                       early;
	logic                       taken;

	assign status.in_is_sample = (action == rlbq_pkg::ACT_SAMPLE);

	assign bound = rlbq_pkg::win_bound(cmd.win, cmd.bnd_hi, tol_q);

	always_comb begin
		if (cmd.mul_num) begin
			opa = $signed({1'b0, series_q});
			opb = $signed(MB_W'(ADC_FULL_SCALE)) - $signed(MB_W'(raw_q));
		end else begin
			opa = {{(rlbq_pkg::OPA_W - rlbq_pkg::BND_W){bound[rlbq_pkg::BND_W-1]}}, bound};
			opb = $signed(MB_W'(raw_q));
		end
	end

	assign mul_res = opa * opb;

	assign win2_hit  = hi_ok_q && (num_q >= prod_q);
	assign onoff_hit = $signed({num_q, 1'b0}) <= $signed((PROD_W + 1)'(raw_q));

	always_comb begin
		priority if (raw_q <= min_raw_q) begin
			sample_req = rlbq_pkg::REQ_NONE;
		end else if (class_q != rlbq_pkg::REQ_NONE) begin
			sample_req = class_q;
		end else if (win2_hit) begin
			sample_req = rlbq_pkg::REQ_CANCEL;
		end else if (onoff_hit) begin
			sample_req = rlbq_pkg::REQ_ONOFF;
		end else begin
			sample_req = rlbq_pkg::REQ_NONE;
		end
	end

	always_comb begin
		unique case (action_q)
			rlbq_pkg::ACT_SAMPLE: req = sample_req;
			rlbq_pkg::ACT_CMD:    req = {1'b0, code_q};
			default:              req = rlbq_pkg::REQ_NONE;
		endcase
	end

	assign offers = (action_q == rlbq_pkg::ACT_SAMPLE) || (action_q == rlbq_pkg::ACT_CMD);
	assign differ = (req != cur_q);
	assign early  = EL_W'(elapsed_q) < EL_W'(holdoff_q);
	assign taken  = offers && !(differ && early);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q <= rlbq_pkg::HOLDOFF_RST;
			tol_q     <= rlbq_pkg::TOL_RST;
			series_q  <= rlbq_pkg::SERIES_RST;
			min_raw_q <= rlbq_pkg::MIN_RAW_RST;
			cur_q     <= rlbq_pkg::REQ_NONE;
			elapsed_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rlbq_pkg::CFG_HOLDOFF: holdoff_q <= cfg_wdata;
					rlbq_pkg::CFG_TOL:     tol_q     <= cfg_wdata[rlbq_pkg::TOL_W-1:0];
					rlbq_pkg::CFG_SERIES:  series_q  <= cfg_wdata;
					rlbq_pkg::CFG_MIN_RAW: min_raw_q <= cfg_wdata[rlbq_pkg::RAW_W-1:0];
					default:               holdoff_q <= holdoff_q;
				endcase
			end
			if (cmd.finish) begin
				if (action_q == rlbq_pkg::ACT_TICK) begin
					if (elapsed_q != '1) begin
						elapsed_q <= elapsed_q + 1'b1;
					end
				end else if (taken) begin
					elapsed_q <= '0;
					cur_q     <= req;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			raw_q    <= adc_sample;
			code_q   <= command_code;
		end
		if (cmd.mul_num) begin
			num_q   <= mul_res;
			class_q <= rlbq_pkg::REQ_NONE;
			hi_ok_q <= 1'b0;
		end
		if (cmd.mul_bnd) begin
			prod_q <= mul_res;
		end
		if (cmd.cmp_en) begin
			if (cmd.cmp_hi) begin
				hi_ok_q <= (num_q <= prod_q);
			end else if (hi_ok_q && (num_q >= prod_q) && (class_q == rlbq_pkg::REQ_NONE)) begin
				class_q <= {1'b0, cmd.cmp_win};
			end
		end
		if (cmd.finish) begin
			held_q    <= taken ? req : cur_q;
			changed_q <= taken && differ;
			req_q     <= req;
		end
	end

	assign held_state      = held_q;
	assign state_changed   = changed_q;
	assign requested_state = req_q;

endmodule

`default_nettype wire

// ===== design/resistor_ladder_button_qualifier.sv =====
// Top level of the resistor ladder button qualifier: controller plus datapath.
// A sample passes one divider multiply and six window-bound multiplies on one shared
// multiplier, then the finish state, where the result loads; a tick or direct command
// goes straight to finish. Finish waits while an earlier result is unaccepted. Input
// reopens as the result loads; a finished result may wait while the next item is taken.
// Reset (arst_n low) restores register defaults, current state none, elapsed zero.
`default_nettype none

module resistor_ladder_button_qualifier #(
	parameter int ADC_FULL_SCALE = 1024,
	parameter int TICK_BITS      = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [rlbq_pkg::ACT_W-1:0]      action,
	input  wire logic [rlbq_pkg::RAW_W-1:0]      adc_sample,
	input  wire logic [rlbq_pkg::CODE_W-1:0]     command_code,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [rlbq_pkg::REQ_W-1:0]           held_state,
	output logic                                 state_changed,
	output logic [rlbq_pkg::REQ_W-1:0]           requested_state,
	input  wire logic                            cfg_we,
	input  wire logic [rlbq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rlbq_pkg::CFG_W-1:0]      cfg_wdata
);

	rlbq_pkg::dp_cmd_t    cmd;
	rlbq_pkg::dp_status_t status;

	rlbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rlbq_dp #(
		.ADC_FULL_SCALE (ADC_FULL_SCALE),
		.TICK_BITS      (TICK_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.action          (action),
		.adc_sample      (adc_sample),
		.command_code    (command_code),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.held_state      (held_state),
		.state_changed   (state_changed),
		.requested_state (requested_state)
	);

endmodule

`default_nettype wire
